FILE: rtl/btr_pkg.sv
// ----------------------------------------------------------------------------
// btr_pkg - shared types and constants of the bitmap glyph text rasteriser
// Font ROM (4x7 glyphs, printable ASCII), field widths, register indexes and
// the small structs that pass between the scanner and the output stage.
// ----------------------------------------------------------------------------
package btr_pkg;

  localparam int MAX_FRAME_WIDTH  = 4096;
  localparam int MAX_FRAME_HEIGHT = 4096;

  localparam int FIRST_PRINTABLE = 32;
  localparam int LAST_PRINTABLE  = 126;
  localparam int CELL_ADVANCE    = 5;
  localparam int CELL_HEIGHT     = 8;
  localparam int COLUMN_MAX      = 8191;

  localparam int GLYPH_BITS  = 28;
  localparam int GLYPH_COUNT = 95;
  localparam int COL_FIRST   = 3;
  localparam int ROW_FIRST   = 6;

  localparam int CODE_W  = 8;
  localparam int COORD_W = 13;
  localparam int PIX_W   = 12;
  localparam int CURX_W  = 14;
  localparam int DIM_W   = 13;
  localparam int LIM_W   = 15;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 13;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic                  load;
    logic [GLYPH_BITS-1:0] glyph;
    logic [PIX_W-1:0]      base_x;
    logic [PIX_W-1:0]      base_y;
  } scan_load_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] x;
  } pix_t;

  localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    28'h0000000, 28'h4440400, 28'hAA00000, 28'h6F6F600,
    28'h27B3E20, 28'hCD6B300, 28'h685A500, 28'h4400000,
    28'h2444200, 28'h4222400, 28'h04EA000, 28'h04E4000,
    28'h0000260, 28'h00E0000, 28'h0000400, 28'h2444800,
    28'h6999600, 28'h6222200, 28'hE168F00, 28'hE161E00,
    28'h26AF200, 28'hF8E1E00, 28'h68E9600, 28'hF124400,
    28'h6969600, 28'h6971600,
    28'h0400400, 28'h0200260, 28'h3484300, 28'h0E0E000,
    28'hC212C00, 28'h6924400, 28'h69B8600,
    28'h699F900, 28'hE9E9E00, 28'h7888700, 28'hE999E00,
    28'hF8F8F00, 28'hF8F8800, 28'h78B9700, 28'h99F9900,
    28'hE444E00, 28'h3119600, 28'h9ACA900, 28'h8888F00,
    28'h9FF9900, 28'h9DB9900, 28'h6999600, 28'hE99E900,
    28'h6999610, 28'hE99E900, 28'h7861E00, 28'hE444400,
    28'h9999600, 28'h99AA400, 28'h99FF900, 28'h9969900,
    28'h9971600, 28'hF168F00,
    28'h6444600, 28'h8444200, 28'h6222600, 28'h4A00000,
    28'h00000F0, 28'h4200000,
    28'h0799700, 28'h8E99E00, 28'h0788700, 28'h1799700,
    28'h06BC600, 28'h24E2200, 28'h0799716, 28'h8E99900,
    28'h4044400, 28'h2022224, 28'h89AE900, 28'h4444400,
    28'h0EBBB00, 28'h0E99900, 28'h0699600, 28'h0E99E88,
    28'h0799711, 28'h0BC8800, 28'h07B3E00, 28'h4E44200,
    28'h0999700, 28'h099A400, 28'h099F600, 28'h0A44A00,
    28'h0999716, 28'h0F24F00,
    28'h64C4600, 28'h4444440, 28'hC464C00, 28'h005A000
  };

  // Glyph of a character code; codes outside the printable range read blank.
  function automatic logic [GLYPH_BITS-1:0] glyph_lookup(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] idx;
    idx = code - CODE_W'(FIRST_PRINTABLE);
    if (code >= CODE_W'(FIRST_PRINTABLE) && code <= CODE_W'(LAST_PRINTABLE)) begin
      return GLYPH_ROM[idx[6:0]];
    end
    return '0;
  endfunction

endpackage

FILE: rtl/btr_scan.sv
// ----------------------------------------------------------------------------
// btr_scan - bit-serial glyph scanner
// Shifts the glyph out one bit per cycle, LSB first, holding on a lit bit
// until taken as a pixel beat; tracks cell row and column; skips clear bits.
// ----------------------------------------------------------------------------
module btr_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  btr_pkg::scan_load_t load_i,
  input  logic               take_i,
  output logic               busy_o,
  output logic               pix_valid_o,
  output btr_pkg::pix_t      pix_o
);
  import btr_pkg::*;

  logic [GLYPH_BITS-1:0] glyph_r, glyph_nxt;
  logic [1:0]            col_r, col_nxt;
  logic [2:0]            row_r, row_nxt;
  logic [PIX_W-1:0]      bx_r, bx_nxt;
  logic [PIX_W-1:0]      by_r, by_nxt;
  logic                  advance;

  assign busy_o      = |glyph_r;
  assign pix_valid_o = glyph_r[0];
  // hold on a lit bit until the output stage takes it
  assign advance     = busy_o && (!glyph_r[0] || take_i);

  assign pix_o.x    = bx_r + {{(PIX_W-2){1'b0}}, col_r};
  assign pix_o.y    = by_r + {{(PIX_W-3){1'b0}}, row_r};
  assign pix_o.last = ~|glyph_r[GLYPH_BITS-1:1];

  always_comb begin
    glyph_nxt = glyph_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    if (load_i.load) begin
      glyph_nxt = load_i.glyph;
      col_nxt   = 2'(COL_FIRST);
      row_nxt   = 3'(ROW_FIRST);
      bx_nxt    = load_i.base_x;
      by_nxt    = load_i.base_y;
    end else if (advance) begin
      glyph_nxt = glyph_r >> 1;
      if (col_r == 2'd0) begin
        col_nxt = 2'(COL_FIRST);
        row_nxt = row_r - 3'd1;
      end else begin
        col_nxt = col_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_r <= '0;
    end else begin
      glyph_r <= glyph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    row_r <= row_nxt;
    bx_r  <= bx_nxt;
    by_r  <= by_nxt;
  end

endmodule

FILE: rtl/btr_obuf.sv
// ----------------------------------------------------------------------------
// btr_obuf - output register of the pixel stream
// One-entry register that takes a new beat whenever it is empty or is being
// drained in the same cycle.
// ----------------------------------------------------------------------------
module btr_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  btr_pkg::pix_t pix_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          ready_i,
  output btr_pkg::pix_t pix_o
);
  import btr_pkg::*;

  logic valid_r, valid_nxt;
  pix_t pix_r, pix_nxt;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign pix_o   = pix_r;

  always_comb begin
    valid_nxt = valid_r;
    pix_nxt   = pix_r;
    if (ready_o) begin
      valid_nxt = valid_i;
      if (valid_i) begin
        pix_nxt = pix_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

endmodule

FILE: rtl/bitmap_glyph_text_rasterizer_top.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_text_rasterizer_top - 4x7 bitmap font text overlay
// Turns character codes into the coordinates of the lit pixels of each glyph.
// ----------------------------------------------------------------------------
// Input channel: one beat per character. A set start flag loads the text
// cursor from start_x/start_y first; the cursor column then advances by 5
// (saturating at 8191) whether or not the glyph is drawn.
// Output channel: one beat per lit pixel, scanned row 6 to 0 and column 3
// to 0; tlast marks the final lit pixel of the character. Unprintable codes,
// blank glyphs and cells outside the frame give no beats.
// Config port: frame width (index 0) and height (index 1), reset 640x480,
// to be written by the user only while idle; the block does not enforce it.
// Timing: a character is taken while the scanner is idle; the scanner then
// walks its glyph one bit per cycle up to the highest lit bit (28 at most),
// holding on a lit bit while the output register cannot take it, and keeps
// the input closed meanwhile; a character that draws nothing lets the next
// follow at once. Each pixel passes from the scanner into the output
// register. The input reopens once the last pixel has moved into the output
// register. A stalled receiver holds the output register and the scanner.
// Reset clears the cursor to 0,0 and empties scanner and output register.
// ----------------------------------------------------------------------------
module bitmap_glyph_text_rasterizer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [btr_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [btr_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // char_code [7:0], start_x [20:8], start_y [33:21], zero [39:34]
  input  logic [btr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // start_flag [0]
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_x [11:0], pixel_y [23:12]
  output logic [btr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import btr_pkg::*;

  localparam logic [CURX_W-1:0] MAX_W    = CURX_W'(MAX_FRAME_WIDTH);
  localparam logic [CURX_W-1:0] MAX_H    = CURX_W'(MAX_FRAME_HEIGHT);
  localparam logic signed [CURX_W-1:0] COL_SAT_LIM = CURX_W'(COLUMN_MAX - CELL_ADVANCE);
  localparam logic signed [CURX_W-1:0] COL_SAT     = CURX_W'(COLUMN_MAX);

  logic [DIM_W-1:0]         fw_r, fw_nxt;
  logic [DIM_W-1:0]         fh_r, fh_nxt;
  logic signed [CURX_W-1:0]  cur_col_r, cur_col_nxt;
  logic signed [COORD_W-1:0] cur_row_r, cur_row_nxt;

  logic [CODE_W-1:0]         code;
  logic signed [CURX_W-1:0]  x;
  logic signed [COORD_W-1:0] y;
  logic [CURX_W-1:0]         w_cap;
  logic [CURX_W-1:0]         h_cap;
  logic                      x_fit, y_fit, draw, in_acc;

  scan_load_t load;
  pix_t       scan_pix, out_pix;
  logic       scan_busy, scan_valid, obuf_ready;

  assign code   = in_tdata[7:0];
  assign x      = in_tuser[0] ? {in_tdata[20], in_tdata[20:8]} : cur_col_r;
  assign y      = in_tuser[0] ? $signed(in_tdata[33:21]) : cur_row_r;
  assign w_cap  = ({1'b0, fw_r} > MAX_W) ? MAX_W : {1'b0, fw_r};
  assign h_cap  = ({1'b0, fh_r} > MAX_H) ? MAX_H : {1'b0, fh_r};
  assign x_fit  = !x[CURX_W-1] &&
                  ({1'b0, x} + LIM_W'(CELL_ADVANCE) <= {1'b0, w_cap});
  assign y_fit  = !y[COORD_W-1] &&
                  ({2'b0, y} + LIM_W'(CELL_HEIGHT) <= {1'b0, h_cap});
  assign draw   = x_fit && y_fit;

  assign in_tready = !scan_busy;
  assign in_acc    = in_tvalid && in_tready;

  assign load.load   = in_acc;
  assign load.glyph  = draw ? glyph_lookup(code) : '0;
  assign load.base_x = x[PIX_W-1:0];
  assign load.base_y = y[PIX_W-1:0];

  always_comb begin
    fw_nxt = fw_r;
    fh_nxt = fh_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  fw_nxt = cfg_wdata;
        REG_FRAME_HEIGHT: fh_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (in_acc) begin
      cur_row_nxt = y;
      cur_col_nxt = (x > COL_SAT_LIM) ? COL_SAT : x + CURX_W'(CELL_ADVANCE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= FRAME_WIDTH_RST;
      fh_r      <= FRAME_HEIGHT_RST;
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      fw_r      <= fw_nxt;
      fh_r      <= fh_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  btr_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .take_i      (obuf_ready),
    .busy_o      (scan_busy),
    .pix_valid_o (scan_valid),
    .pix_o       (scan_pix)
  );

  btr_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (scan_valid),
    .pix_i   (scan_pix),
    .ready_o (obuf_ready),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .pix_o   (out_pix)
  );

  assign out_tdata = {out_pix.y, out_pix.x};
  assign out_tlast = out_pix.last;

endmodule

FILE: rtl/btr_chk.sv
// ----------------------------------------------------------------------------
// btr_chk - port-level checks of the text rasteriser
// Watches the input and pixel channels of the top level over time.
// ----------------------------------------------------------------------------
module btr_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [btr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [btr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import btr_pkg::*;

  // pixel channel is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("pixel beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled pixel beat changed");

  // an unprintable code draws nothing, so the input stays open
  a_unprintable_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tdata[7:0] < 8'(FIRST_PRINTABLE) || in_tdata[7:0] > 8'(LAST_PRINTABLE))
    |=> in_tready)
    else $error("input closed after unprintable code");

  // a non-final beat on offer means the final one is still in the scanner
  a_glyph_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open while glyph pixels remain");

endmodule

bind bitmap_glyph_text_rasterizer_top btr_chk u_btr_chk (.*);
